// ===== sv/lsdl_pkg.sv =====
package lsdl_pkg;

    // operation codes of an input transaction
    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_STRENGTHEN = 3'd1;
    localparam logic [2:0] OP_WEAKEN     = 3'd2;
    localparam logic [2:0] OP_WEIGHT     = 3'd3;
    localparam logic [2:0] OP_RELOAD     = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_CELL_COUNT   = 3'd0;
    localparam logic [2:0] REG_LOSS_BASE    = 3'd1;
    localparam logic [2:0] REG_LOSS_PER_IND = 3'd2;
    localparam logic [2:0] REG_SMOOTHING    = 3'd3;
    localparam logic [2:0] REG_BASE_IND     = 3'd4;
    localparam logic [2:0] REG_SOURCE_Z     = 3'd5;
    localparam logic [2:0] REG_SINK_Z       = 3'd6;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [15:0] L_MIN       = 16'd102;
    localparam logic [15:0] L_MAX       = 16'd51200;
    localparam logic [15:0] L_RESET     = 16'd1024;
    localparam logic [15:0] Z_THRESHOLD = 16'd1024;

    // exp(-0.7 d) in Q1.16
    localparam logic [16:0] DECAY_Q16 [8] = '{
        17'd65536, 17'd32544, 17'd16161, 17'd8025,
        17'd3985,  17'd1979,  17'd983,   17'd488
    };

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_ATT        = 3'd1,
        CMD_INC        = 3'd2,
        CMD_MIX        = 3'd3,
        CMD_STRENGTHEN = 3'd4,
        CMD_WEAKEN     = 3'd5,
        CMD_LOAD       = 3'd6
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic               drive;
        logic signed [15:0] drive_value;
        logic               hold;
        logic [15:0]        loss_base;
        logic [15:0]        loss_g;
        logic [15:0]        alpha;
        logic [16:0]        keep;
        logic [15:0]        rate;
        logic [15:0]        base;
    } cell_ctl_t;

endpackage

// ===== sv/lsdl_if.sv =====
interface lsdl_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic               drive;
    logic signed [15:0] drive_value;
    logic [15:0]        rate;

    modport source (output valid, output op, output drive, output drive_value,
                    output rate, input ready);
    modport sink (input valid, input op, input drive, input drive_value,
                  input rate, output ready);
endinterface

interface lsdl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] far_value;
    logic [7:0]         weight;

    modport source (output valid, output far_value, output weight, input ready);
    modport sink (input valid, input far_value, input weight, output ready);
endinterface

// ===== sv/lossy_smoothing_delay_line.sv =====
// tick: attenuation, increment and mix steps, then the result; next transaction taken once idle again
// strengthen / weaken: one scaling pass through all cells at once, then the result
// weight query: attenuation, then the serial gain product over the n cells in use, then the weight
// reload: base inductance written on acceptance, then the two-step bump write per end cell
// asynchronous active-low reset: values 0, inductances 1.0, source hold set, registers
// to their defaults; no clearing pass, the block is ready right after reset
module lossy_smoothing_delay_line #(
    parameter int MAX_CELLS  = 64,
    parameter int BUMP_DEPTH = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    lsdl_in_if.sink     in_ch,
    lsdl_out_if.source  out_ch
);

    localparam int NW = $clog2(MAX_CELLS + 1);
    localparam int IW = $clog2(MAX_CELLS);
    localparam int JW = (BUMP_DEPTH > 1) ? $clog2(2 * BUMP_DEPTH) : 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ATT   = 9'b000000010,
        S_INC   = 9'b000000100,
        S_MIX   = 9'b000001000,
        S_SCALE = 9'b000010000,
        S_GAIN  = 9'b000100000,
        S_WFIN  = 9'b001000000,
        S_BUMP  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [6:0]  cell_count_reg;
    logic [15:0] loss_base_reg, loss_g_reg, alpha_reg, base_reg, src_z_reg, sink_z_reg;

    // captured transaction
    logic [2:0]         op_reg;
    logic               drive_reg;
    logic signed [15:0] dval_reg;
    logic [15:0]        rate_reg;

    logic               hold_reg;
    logic [IW-1:0]      k_reg;
    logic [16:0]        gain_reg;
    logic [7:0]         weight_reg;
    logic [JW-1:0]      j_reg;
    logic               bump_phase_reg;   // 0: scale factor, 1: inductance write
    logic [15:0]        s_reg;

    logic               out_valid_reg;
    logic signed [15:0] out_far_reg;
    logic [7:0]         out_weight_reg;

    logic [NW-1:0]      n_used;
    logic [IW-1:0]      last_idx;
    lsdl_pkg::cell_ctl_t ctl;
    logic signed [15:0] value_all [MAX_CELLS];
    logic [16:0]        att_all [MAX_CELLS];

    // cells in use, saturated to 4..MAX_CELLS
    always_comb
    begin
        if (cell_count_reg < 7'd4)
            n_used = NW'(4);
        else if (32'(cell_count_reg) > MAX_CELLS)
            n_used = NW'(MAX_CELLS);
        else
            n_used = NW'(cell_count_reg);
    end

    assign last_idx = IW'(n_used - NW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg <= 7'd8;
            loss_base_reg  <= 16'd9830;
            loss_g_reg     <= 16'd1311;
            alpha_reg      <= 16'd32768;
            base_reg       <= 16'd1024;
            src_z_reg      <= 16'd1024;
            sink_z_reg     <= 16'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsdl_pkg::REG_CELL_COUNT:   cell_count_reg <= cfg_data[6:0];
                lsdl_pkg::REG_LOSS_BASE:    loss_base_reg  <= cfg_data;
                lsdl_pkg::REG_LOSS_PER_IND: loss_g_reg     <= cfg_data;
                lsdl_pkg::REG_SMOOTHING:    alpha_reg      <= cfg_data;
                lsdl_pkg::REG_BASE_IND:     base_reg       <= cfg_data;
                lsdl_pkg::REG_SOURCE_Z:     src_z_reg      <= cfg_data;
                lsdl_pkg::REG_SINK_Z:       sink_z_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // bump step: which end, distance, and target cell
    logic          bump_far;
    logic [2:0]    bump_d;
    logic [15:0]   bump_z;
    logic [32:0]   bump_s_prod;
    logic [15:0]   bump_s;
    logic [32:0]   bump_l_prod;
    logic [22:0]   bump_l;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [15:0]   wr_val;

    always_comb
    begin
        bump_far = 32'(j_reg) >= BUMP_DEPTH;
        bump_d   = bump_far ? 3'(32'(j_reg) - BUMP_DEPTH) : 3'(j_reg);
        bump_z   = bump_far ? sink_z_reg : src_z_reg;
        bump_s_prod = 33'(bump_z) * 33'(lsdl_pkg::DECAY_Q16[bump_d]) + 33'd32768;
        bump_s = (bump_s_prod[32:16] < 17'd1024) ? 16'd1024 : bump_s_prod[31:16];
        bump_l_prod = 33'(base_reg) * 33'(s_reg) + 33'd512;
        bump_l = bump_l_prod[32:10];
        wr_val = (bump_l > 23'd65535) ? 16'hffff : bump_l[15:0];
        wr_idx = bump_far ? IW'(last_idx - IW'(bump_d)) : IW'(bump_d);
        wr_en  = (state_reg == S_BUMP) && bump_phase_reg
                 && (bump_z > lsdl_pkg::Z_THRESHOLD) && (NW'(bump_d) < n_used);
    end

    // serial gain product and final weight
    logic [33:0] gain_prod;
    logic [24:0] w_prod;
    logic [8:0]  w_raw;

    always_comb
    begin
        gain_prod = 34'(gain_reg) * 34'(att_all[k_reg]) + 34'd32768;
        w_prod    = 25'(gain_reg) * 25'd255 + 25'd32768;
        w_raw     = w_prod[24:16];
    end

    // broadcast to the cell row
    always_comb
    begin
        ctl.drive       = drive_reg && (op_reg == lsdl_pkg::OP_TICK);
        ctl.drive_value = dval_reg;
        ctl.hold        = hold_reg;
        ctl.loss_base   = loss_base_reg;
        ctl.loss_g      = loss_g_reg;
        ctl.alpha       = alpha_reg;
        ctl.keep        = lsdl_pkg::ONE_Q16 - 17'(alpha_reg);
        ctl.rate        = rate_reg;
        ctl.base        = base_reg;
        case (state_reg)
            S_ATT:   ctl.cmd = lsdl_pkg::CMD_ATT;
            S_INC:   ctl.cmd = lsdl_pkg::CMD_INC;
            S_MIX:   ctl.cmd = lsdl_pkg::CMD_MIX;
            S_SCALE: ctl.cmd = (op_reg == lsdl_pkg::OP_WEAKEN) ? lsdl_pkg::CMD_WEAKEN
                                                               : lsdl_pkg::CMD_STRENGTHEN;
            default: ctl.cmd = lsdl_pkg::CMD_NONE;
        endcase
        // reload writes the base inductance as the item is taken
        if (state_reg == S_IDLE && in_ch.valid && in_ch.op == lsdl_pkg::OP_RELOAD)
            ctl.cmd = lsdl_pkg::CMD_LOAD;
    end

    // the row of cells; cell 0 takes its own value as predecessor
    for (genvar i = 0; i < MAX_CELLS; i++)
    begin : g_cell
        logic signed [15:0] prev;
        if (i == 0)
        begin : g_head
            assign prev = value_all[0];
        end
        else
        begin : g_body
            assign prev = value_all[i-1];
        end
        lsdl_cell #(
            .MAX_CELLS (MAX_CELLS),
            .IDX       (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .n_used     (n_used),
            .wr_en      (wr_en),
            .wr_idx     (wr_idx),
            .wr_val     (wr_val),
            .prev_value (prev),
            .value      (value_all[i]),
            .atten      (att_all[i])
        );
    end

    logic out_free;
    assign out_free = !out_valid_reg || out_ch.ready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    case (in_ch.op)
                        lsdl_pkg::OP_TICK, lsdl_pkg::OP_WEIGHT: state_next = S_ATT;
                        lsdl_pkg::OP_STRENGTHEN, lsdl_pkg::OP_WEAKEN: state_next = S_SCALE;
                        lsdl_pkg::OP_RELOAD: state_next = S_BUMP;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_ATT:   state_next = (op_reg == lsdl_pkg::OP_TICK) ? S_INC : S_GAIN;
            S_INC:   state_next = S_MIX;
            S_MIX:   state_next = S_DONE;
            S_SCALE: state_next = S_DONE;
            S_GAIN:  state_next = (k_reg == last_idx) ? S_WFIN : S_GAIN;
            S_WFIN:  state_next = S_DONE;
            S_BUMP:
            begin
                if (bump_phase_reg && j_reg == JW'(2 * BUMP_DEPTH - 1))
                    state_next = S_DONE;
            end
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hold_reg       <= 1'b1;
            out_valid_reg  <= 1'b0;
            k_reg          <= '0;
            j_reg          <= '0;
            bump_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    k_reg          <= '0;
                    j_reg          <= '0;
                    bump_phase_reg <= 1'b0;
                    if (in_ch.valid && in_ch.op == lsdl_pkg::OP_RELOAD)
                        hold_reg <= 1'b1;
                end
                S_ATT:
                begin
                    if (ctl.drive)
                        hold_reg <= 1'b1;
                end
                S_MIX:
                    hold_reg <= 1'b0;
                S_GAIN:
                    k_reg <= k_reg + IW'(1);
                S_BUMP:
                begin
                    bump_phase_reg <= !bump_phase_reg;
                    if (bump_phase_reg)
                        j_reg <= j_reg + JW'(1);
                end
                S_DONE:
                begin
                    if (out_free)
                        out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            op_reg     <= in_ch.op;
            drive_reg  <= in_ch.drive;
            dval_reg   <= in_ch.drive_value;
            rate_reg   <= in_ch.rate;
            weight_reg <= 8'd0;
            gain_reg   <= lsdl_pkg::ONE_Q16;
        end
        if (state_reg == S_GAIN)
            gain_reg <= gain_prod[32:16];
        if (state_reg == S_WFIN)
        begin
            if (w_raw < 9'd1)
                weight_reg <= 8'd1;
            else if (w_raw > 9'd254)
                weight_reg <= 8'd254;
            else
                weight_reg <= w_raw[7:0];
        end
        if (state_reg == S_BUMP && !bump_phase_reg)
            s_reg <= bump_s;
        if (state_reg == S_DONE && out_free)
        begin
            out_far_reg    <= value_all[last_idx];
            out_weight_reg <= weight_reg;
        end
    end

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.far_value = out_far_reg;
    assign out_ch.weight    = out_weight_reg;

endmodule

// ===== sv/lsdl_cell.sv =====
module lsdl_cell #(
    parameter int MAX_CELLS = 64,
    parameter int IDX       = 0,
    localparam int NW = $clog2(MAX_CELLS + 1),
    localparam int IW = $clog2(MAX_CELLS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lsdl_pkg::cell_ctl_t  ctl,
    input  logic [NW-1:0]        n_used,
    input  logic                 wr_en,
    input  logic [IW-1:0]        wr_idx,
    input  logic [15:0]          wr_val,
    input  logic signed [15:0]   prev_value,
    output logic signed [15:0]   value,
    output logic [16:0]          atten
);

    logic signed [15:0] value_reg;
    logic [15:0]        ind_reg;
    logic [16:0]        att_reg;
    logic signed [16:0] inc_reg;

    logic               active;
    logic [31:0]        gl_prod;
    logic [22:0]        loss;
    logic [16:0]        att_next;
    logic signed [33:0] inc_prod;
    logic signed [33:0] inc_round;
    logic signed [34:0] mix_sum;
    logic signed [34:0] mix_round;
    logic signed [18:0] mix_q;
    logic signed [15:0] mix_sat;
    logic signed [15:0] inc_sat;
    logic [16:0]        scale_f;
    logic [33:0]        scale_prod;
    logic [17:0]        scale_l;
    logic [15:0]        scale_next;

    assign active = n_used > NW'(IDX);

    // attenuation 1 - (R + G*L), floored at zero
    always_comb
    begin
        gl_prod = 32'(ctl.loss_g) * 32'(ind_reg);
        loss = 23'(ctl.loss_base) + 23'((33'(gl_prod) + 33'd512) >> 10);
        if (loss >= 23'(lsdl_pkg::ONE_Q16))
            att_next = 17'd0;
        else
            att_next = 17'(23'(lsdl_pkg::ONE_Q16) - loss);
    end

    always_comb
    begin
        inc_prod  = 34'($signed(prev_value)) * $signed({17'd0, att_reg});
        inc_round = (inc_prod + 34'sd32768) >>> 16;
        if (inc_reg > 17'sd32767)
            inc_sat = 16'sh7fff;
        else
            inc_sat = inc_reg[15:0];
    end

    always_comb
    begin
        mix_sum = 35'(inc_reg) * $signed({19'd0, ctl.alpha})
                + 35'(value_reg) * $signed({18'd0, ctl.keep});
        mix_round = (mix_sum + 35'sd32768) >>> 16;
        mix_q = mix_round[18:0];
        if (mix_q > 19'sd32767)
            mix_sat = 16'sh7fff;
        else if (mix_q < -19'sd32768)
            mix_sat = -16'sh8000;
        else
            mix_sat = mix_q[15:0];
    end

    // inductance scaling by (1 - rate) or (1 + rate)
    always_comb
    begin
        if (ctl.cmd == lsdl_pkg::CMD_WEAKEN)
            scale_f = lsdl_pkg::ONE_Q16 + 17'(ctl.rate);
        else
            scale_f = lsdl_pkg::ONE_Q16 - 17'(ctl.rate);
        scale_prod = 34'(ind_reg) * 34'(scale_f) + 34'd32768;
        scale_l = scale_prod[33:16];
        if (ctl.cmd == lsdl_pkg::CMD_WEAKEN)
            scale_next = (scale_l > 18'(lsdl_pkg::L_MAX)) ? lsdl_pkg::L_MAX
                                                          : scale_l[15:0];
        else
            scale_next = (scale_l < 18'(lsdl_pkg::L_MIN)) ? lsdl_pkg::L_MIN
                                                          : scale_l[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            ind_reg   <= lsdl_pkg::L_RESET;
        end
        else
        begin
            case (ctl.cmd)
                lsdl_pkg::CMD_ATT:
                begin
                    if (IDX == 0 && ctl.drive)
                        value_reg <= ctl.drive_value;
                end
                lsdl_pkg::CMD_MIX:
                begin
                    if (IDX == 0)
                    begin
                        if (!ctl.hold)
                            value_reg <= inc_sat;
                    end
                    else if (active)
                        value_reg <= mix_sat;
                end
                lsdl_pkg::CMD_STRENGTHEN, lsdl_pkg::CMD_WEAKEN:
                begin
                    if (active)
                        ind_reg <= scale_next;
                end
                lsdl_pkg::CMD_LOAD:
                    ind_reg <= ctl.base;
                default:
                begin
                end
            endcase
            if (wr_en && wr_idx == IW'(IDX))
                ind_reg <= wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmd == lsdl_pkg::CMD_ATT)
            att_reg <= att_next;
        if (ctl.cmd == lsdl_pkg::CMD_INC)
            inc_reg <= inc_round[16:0];
    end

    assign value = value_reg;
    assign atten = att_reg;

endmodule

// ===== verif/lsdl_tb_if.sv =====
`timescale 1ns / 1ps

// the channels come from the rtl interface file; this file only keeps the
// transaction types that the bench passes between its processes
package lsdl_tb_pkg;

    typedef struct {
        logic [2:0]         op;
        logic               drive;
        logic signed [15:0] drive_value;
        logic [15:0]        rate;
    } line_in_t;

    typedef struct {
        logic signed [15:0] far_value;
        logic [7:0]         weight;
    } line_out_t;

endpackage

// ===== verif/lossy_smoothing_delay_line_tb.sv =====
`timescale 1ns / 1ps

module lossy_smoothing_delay_line_tb;

    localparam int NCELLS = 64;
    localparam int BUMPS  = 3;
    localparam int LIMIT  = 1500000;

    // shadow of the line: values, inductances, registers and source hold
    class line_scoreboard;
        logic signed [15:0] val [NCELLS];
        logic [15:0]        ind [NCELLS];
        bit                 hold;
        logic [6:0]         cnt;
        logic [15:0]        rb, gl, alpha, base_l, zs, zk;
        lsdl_tb_pkg::line_out_t pending [$];
        int                 errors;

        function new();
            for (int i = 0; i < NCELLS; i++)
            begin
                val[i] = 16'sd0;
                ind[i] = lsdl_pkg::L_RESET;
            end
            hold = 1'b1; cnt = 7'd8; rb = 16'd9830; gl = 16'd1311; alpha = 16'd32768;
            base_l = 16'd1024; zs = 16'd1024; zk = 16'd1024; errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] d);
            case (idx)
                lsdl_pkg::REG_CELL_COUNT:   cnt = d[6:0];
                lsdl_pkg::REG_LOSS_BASE:    rb = d;
                lsdl_pkg::REG_LOSS_PER_IND: gl = d;
                lsdl_pkg::REG_SMOOTHING:    alpha = d;
                lsdl_pkg::REG_BASE_IND:     base_l = d;
                lsdl_pkg::REG_SOURCE_Z:     zs = d;
                lsdl_pkg::REG_SINK_Z:       zk = d;
                default: ;
            endcase
        endfunction

        function int used();
            if (cnt < 4) return 4;
            if (cnt > NCELLS) return NCELLS;
            return int'(cnt);
        endfunction

        function longint atten(int i);
            longint loss;
            loss = longint'(rb) + ((longint'(gl) * longint'(ind[i]) + 512) >>> 10);
            return (loss >= 65536) ? 0 : 65536 - loss;
        endfunction

        // divide by 2^16, rounding half up (floor of x + 0.5)
        function longint rnd16(longint x);
            return (x + 32768) >>> 16;
        endfunction

        function logic signed [15:0] sat(longint x);
            if (x > 32767) return 16'sh7fff;
            if (x < -32768) return -16'sh8000;
            return x[15:0];
        endfunction

        function void bump(logic [15:0] z, bit far_end, int n);
            longint s, l;
            int idx;
            if (z <= lsdl_pkg::Z_THRESHOLD) return;
            for (int d = 0; d < BUMPS && d < n; d++)
            begin
                s = (longint'(z) * longint'(lsdl_pkg::DECAY_Q16[d]) + 32768) >>> 16;
                if (s < 1024) s = 1024;
                l = (longint'(base_l) * s + 512) >>> 10;
                if (l > 65535) l = 65535;
                idx = far_end ? n - 1 - d : d;
                ind[idx] = l[15:0];
            end
        endfunction

        // note an accepted input transaction and queue the predicted result
        function void note_input(lsdl_tb_pkg::line_in_t t);
            int n;
            longint g, w, inc, mix, l;
            lsdl_tb_pkg::line_out_t r;
            n = used();
            r.weight = 8'd0;
            case (t.op)
                lsdl_pkg::OP_TICK:
                begin
                    if (t.drive)
                    begin
                        val[0] = t.drive_value;
                        hold = 1'b1;
                    end
                    for (int i = n - 1; i >= 1; i--)
                    begin
                        inc = rnd16(longint'(val[i-1]) * atten(i));
                        mix = inc * longint'(alpha)
                            + longint'(val[i]) * (65536 - longint'(alpha));
                        val[i] = sat(rnd16(mix));
                    end
                    if (hold) hold = 1'b0;
                    else val[0] = sat(rnd16(longint'(val[0]) * atten(0)));
                end
                lsdl_pkg::OP_STRENGTHEN, lsdl_pkg::OP_WEAKEN:
                    for (int i = 0; i < n; i++)
                    begin
                        if (t.op == lsdl_pkg::OP_WEAKEN)
                        begin
                            l = longint'(ind[i]) * (65536 + longint'(t.rate));
                            l = (l + 32768) >>> 16;
                            if (l > longint'(lsdl_pkg::L_MAX)) l = longint'(lsdl_pkg::L_MAX);
                        end
                        else
                        begin
                            l = longint'(ind[i]) * (65536 - longint'(t.rate));
                            l = (l + 32768) >>> 16;
                            if (l < longint'(lsdl_pkg::L_MIN)) l = longint'(lsdl_pkg::L_MIN);
                        end
                        ind[i] = l[15:0];
                    end
                lsdl_pkg::OP_WEIGHT:
                begin
                    g = 65536;
                    for (int i = 0; i < n; i++)
                        g = (g * atten(i) + 32768) >>> 16;
                    w = (g * 255 + 32768) >>> 16;
                    if (w < 1) w = 1;
                    if (w > 254) w = 254;
                    r.weight = w[7:0];
                end
                lsdl_pkg::OP_RELOAD:
                begin
                    for (int i = 0; i < NCELLS; i++)
                        ind[i] = base_l;
                    bump(zs, 1'b0, n);
                    bump(zk, 1'b1, n);
                    hold = 1'b1;
                end
                default: ;
            endcase
            r.far_value = val[n-1];
            pending.push_back(r);
        endfunction

        function void check_result(lsdl_tb_pkg::line_out_t a);
            lsdl_tb_pkg::line_out_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending: far_value %0d", a.far_value);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.far_value !== e.far_value)
            begin
                $error("far_value expected %0d actual %0d", e.far_value, a.far_value);
                errors++;
            end
            if (a.weight !== e.weight)
            begin
                $error("weight expected %0d actual %0d", e.weight, a.weight);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    lsdl_in_if  in_ch ();
    lsdl_out_if out_ch ();

    lossy_smoothing_delay_line uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    line_scoreboard sb;
    int  cycles;
    bit  long_hold;   // receiver holds off for a long stretch while set
    bit  sink_idle;   // receiver stalls at random only while clear

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("lossy_smoothing_delay_line_tb: done, errors");
                $finish;
            end
        end
    end

    // random gap length: mostly short, a few long
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(10, 40));
        return int'($urandom_range(0, 3));
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int g;
        out_ch.ready = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result('{far_value: out_ch.far_value, weight: out_ch.weight});
            if (long_hold)
                out_ch.ready <= 0;
            else if (!sink_idle && $urandom_range(0, 3) == 0)
            begin
                g = gap_len();
                out_ch.ready <= (g == 0);
                if (g > 0)
                begin
                    repeat (g - 1)
                    begin
                        @(posedge clk);
                        if (out_ch.valid && out_ch.ready)
                            sb.check_result('{far_value: out_ch.far_value,
                                              weight: out_ch.weight});
                    end
                    out_ch.ready <= 1;
                end
            end
            else
                out_ch.ready <= 1;
        end
    end

    // long hold-off counted in its own process
    task automatic hold_receiver(int len);
        long_hold = 1;
        repeat (len) @(posedge clk);
        long_hold = 0;
    endtask

    // offer one transaction, wait for its acceptance
    task automatic send(lsdl_tb_pkg::line_in_t t, bit gaps);
        int g;
        g = gaps ? ($urandom_range(0, 2) == 0 ? gap_len() : 0) : 0;
        if (g > 0)
        begin
            in_ch.valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid       <= 1;
        in_ch.op          <= t.op;
        in_ch.drive       <= t.drive;
        in_ch.drive_value <= t.drive_value;
        in_ch.rate        <= t.rate;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_input(t);
    endtask

    task automatic idle_line();
        @(posedge clk);
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] d);
        @(posedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we <= 0;
        sb.write_reg(idx, d);
    endtask

    function automatic lsdl_tb_pkg::line_in_t mk(logic [2:0] op, logic drive,
                                                 logic [15:0] dv, logic [15:0] rate);
        lsdl_tb_pkg::line_in_t t;
        t.op = op; t.drive = drive; t.drive_value = dv; t.rate = rate;
        return t;
    endfunction

    // mostly ticks with random drive, occasional scaling, queries and reloads
    function automatic lsdl_tb_pkg::line_in_t rand_item();
        int k;
        logic [15:0] dv;
        logic [15:0] rt;
        logic        dr;
        k  = int'($urandom_range(0, 99));
        dv = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 16'h7fff : 16'h8000)
                                         : 16'($urandom);
        rt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8000));
        dr = 1'($urandom_range(0, 1));
        if (k < 60) return mk(lsdl_pkg::OP_TICK, dr, dv, rt);
        if (k < 70) return mk(lsdl_pkg::OP_STRENGTHEN, dr, dv, rt);
        if (k < 80) return mk(lsdl_pkg::OP_WEAKEN, dr, dv, rt);
        if (k < 90) return mk(lsdl_pkg::OP_WEIGHT, dr, dv, rt);
        if (k < 96) return mk(lsdl_pkg::OP_RELOAD, dr, dv, rt);
        return mk(3'($urandom_range(5, 7)), dr, dv, rt);
    endfunction

    // one setting per phase: count, R, G, alpha, base, source z, sink z
    typedef logic [15:0] setting_t [7];

    initial
    begin
        setting_t phases [6];
        int per_phase;
        sb = new();
        rst_n = 0;
        cfg_we = 0; cfg_index = lsdl_pkg::REG_CELL_COUNT; cfg_data = 0;
        in_ch.valid = 0; in_ch.op = lsdl_pkg::OP_TICK; in_ch.drive = 0;
        in_ch.drive_value = 0; in_ch.rate = 0;
        long_hold = 0; sink_idle = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // directed part on reset settings
        send(mk(lsdl_pkg::OP_TICK, 1'b1, 16'h7fff, 16'd0), 1'b0);
        send(mk(lsdl_pkg::OP_TICK, 1'b0, 16'd0, 16'd0), 1'b0);
        send(mk(lsdl_pkg::OP_TICK, 1'b0, 16'd0, 16'd0), 1'b0);
        send(mk(lsdl_pkg::OP_TICK, 1'b1, 16'h8000, 16'd0), 1'b0);
        send(mk(lsdl_pkg::OP_TICK, 1'b0, 16'd0, 16'd0), 1'b0);
        // drive ignored, floor at 0.1
        send(mk(lsdl_pkg::OP_STRENGTHEN, 1'b1, 16'h1234, 16'hffff), 1'b0);
        send(mk(lsdl_pkg::OP_WEIGHT, 1'b0, 16'd0, 16'd0), 1'b0);
        send(mk(lsdl_pkg::OP_WEAKEN, 1'b0, 16'd0, 16'hffff), 1'b0);
        // up to the 50.0 ceiling
        repeat (12) send(mk(lsdl_pkg::OP_WEAKEN, 1'b0, 16'd0, 16'hffff), 1'b0);
        send(mk(lsdl_pkg::OP_WEIGHT, 1'b0, 16'd0, 16'd0), 1'b0);   // weight clamps low
        send(mk(lsdl_pkg::OP_RELOAD, 1'b0, 16'd0, 16'd0), 1'b0);
        send(mk(lsdl_pkg::OP_TICK, 1'b0, 16'd0, 16'd0), 1'b0);     // source held after reload
        send(mk(lsdl_pkg::OP_TICK, 1'b0, 16'd0, 16'd0), 1'b0);
        send(mk(3'd5, 1'b1, 16'h7fff, 16'd0), 1'b0);               // unused op codes
        send(mk(3'd7, 1'b0, 16'd0, 16'hffff), 1'b0);
        send(mk(lsdl_pkg::OP_WEIGHT, 1'b0, 16'd0, 16'd0), 1'b0);
        idle_line();

        phases[0] = '{16'd2,   16'd0,     16'd0,     16'd65535, 16'd102,   16'd65535, 16'd0};
        phases[1] = '{16'd127, 16'd65535, 16'd65535, 16'd0,     16'd51200, 16'd0,     16'd65535};
        phases[2] = '{16'd4,   16'd500,   16'd300,   16'd40000, 16'd2048,  16'd4000,  16'd3000};
        phases[3] = '{16'd64,  16'd100,   16'd200,   16'd50000, 16'd900,   16'd1025,  16'd1024};
        phases[4] = '{16'd5,   16'd0,     16'd10,    16'd20000, 16'd30000, 16'd65535, 16'd65535};
        phases[5] = '{16'd16,  16'd2000,  16'd1311,  16'd32768, 16'd1024,  16'd2500,  16'd9000};
        per_phase = 220;

        for (int p = 0; p < 6; p++)
        begin
            for (int r = 0; r < 7; r++)
                write_reg(3'(r), phases[p][r]);
            send(mk(lsdl_pkg::OP_RELOAD, 1'b0, 16'd0, 16'd0), 1'b1);
            send(mk(lsdl_pkg::OP_WEIGHT, 1'b0, 16'd0, 16'd0), 1'b1);
            sink_idle = (p == 3);  // stretch with no receiver stalls
            for (int k = 0; k < per_phase; k++)
            begin
                if (p == 2 && k == 50)
                    fork
                        hold_receiver(300);
                    join_none
                send(rand_item(), p != 3);
            end
            sink_idle = 0;
            idle_line();
        end

        if (sb.errors == 0)
            $display("lossy_smoothing_delay_line_tb: done, clean");
        else
            $display("lossy_smoothing_delay_line_tb: done, errors");
        $finish;
    end

endmodule

// ===== lossy_smoothing_delay_line.f =====
sv/lsdl_pkg.sv
sv/lsdl_if.sv
sv/lsdl_cell.sv
sv/lossy_smoothing_delay_line.sv
verif/lsdl_tb_if.sv
verif/lossy_smoothing_delay_line_tb.sv
